[sv/ffle_pkg.sv]
`default_nettype none

package ffle_pkg;

    // Field widths of the input and output words.
    localparam int FLAME_W     = 6;
    localparam int STEP_W      = 7;
    localparam int PEAK_DRAW_W = 9;
    localparam int COLOR_W     = 5;
    localparam int DRAW_W      = 16;
    localparam int PIX_W       = 8;
    localparam int CHAN_W      = 8;
    localparam int THR_W       = 10;

    // Brightness and colour arithmetic.
    localparam int LEVEL_W          = 10;
    localparam int HALF_RANGE       = 384;
    localparam int COLOR_COUNT      = 22;
    localparam int CHANNELS         = 3;
    localparam int PIXELS_PER_FLAME = 3;
    localparam int CH_RED           = 0;
    localparam int CH_GREEN         = 1;
    localparam int CH_BLUE          = 2;

    // Serial units: the product is table * level, the quotient is taken of
    // product / 256 by nine, which gives both channel / 3 and channel mod 3.
    localparam int PROD_W      = 20;
    localparam int SCALE_SHIFT = 8;
    localparam int QUO_W       = 9;
    localparam int REM_W       = 4;
    localparam int DIVISOR     = 9;
    localparam int MOD_STEPS   = DRAW_W;
    localparam int MUL_STEPS   = LEVEL_W;
    localparam int DIV_STEPS   = PROD_W - SCALE_SHIFT;

    localparam logic [REM_W-1:0]  R9_ONE     = 4'd3;
    localparam logic [REM_W-1:0]  R9_TWO     = 4'd6;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;
    localparam logic [STEP_W-1:0] STEP_MAX   = 7'd127;
    localparam logic [THR_W-1:0]  THR_RESET  = 10'd3;
    localparam logic [1:0]        SUB_LAST   = 2'(PIXELS_PER_FLAME - 1);

    // Colour table levels: full scale times 1, 0.5, 0.4, 0.3, 0.2 and 0.
    localparam logic [LEVEL_W-1:0] LV_FULL = 10'd768;
    localparam logic [LEVEL_W-1:0] LV_HALF = 10'd384;
    localparam logic [LEVEL_W-1:0] LV_40   = 10'd307;
    localparam logic [LEVEL_W-1:0] LV_30   = 10'd230;
    localparam logic [LEVEL_W-1:0] LV_20   = 10'd153;
    localparam logic [LEVEL_W-1:0] LV_ZERO = 10'd0;

    typedef enum logic [1:0] {
        PH_NEW  = 2'd0,
        PH_RISE = 2'd1,
        PH_FALL = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_MOD,
        SQ_SCALE,
        SQ_HAND
    } seq_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } scl_state_t;

    typedef struct packed {
        logic [FLAME_W-1:0]     flame_index;
        logic [STEP_W-1:0]      step_draw;
        logic [PEAK_DRAW_W-1:0] peak_draw;
        logic [COLOR_W-1:0]     color_draw;
        logic [DRAW_W-1:0]      flicker_draw;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_index;
        logic [CHAN_W-1:0] red_level;
        logic [CHAN_W-1:0] green_level;
        logic [CHAN_W-1:0] blue_level;
        logic              last_pixel;
    } out_item_t;

    typedef struct packed {
        phase_t               phase;
        logic [LEVEL_W-1:0]   level;
        logic [STEP_W-1:0]    step;
        logic [LEVEL_W-1:0]   peak;
        logic [COLOR_W-1:0]   color;
    } flame_entry_t;

    typedef struct packed {
        logic [CHANNELS-1:0][QUO_W-1:0] quo;
        logic [CHANNELS-1:0][1:0]       rem;
    } scale_res_t;

    function automatic logic [STEP_W-1:0] make_step(input logic [STEP_W-1:0] draw);
        logic [STEP_W:0] s;
        s = (STEP_W + 1)'(draw) + (STEP_W + 1)'(1);
        return (s > (STEP_W + 1)'(STEP_MAX)) ? STEP_MAX : s[STEP_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] make_peak(input logic [PEAK_DRAW_W-1:0] draw);
        return LEVEL_W'(HALF_RANGE) + LEVEL_W'(draw);
    endfunction

    function automatic logic [COLOR_W-1:0] color_sat(input logic [COLOR_W-1:0] draw);
        return (int'(draw) < COLOR_COUNT) ? draw : COLOR_W'(COLOR_COUNT - 1);
    endfunction

    function automatic logic [CHANNELS-1:0][LEVEL_W-1:0] color_scale(
        input logic [COLOR_W-1:0] idx
    );
        logic [CHANNELS-1:0][LEVEL_W-1:0] rgb;
        rgb[CH_RED]   = LV_FULL;
        rgb[CH_GREEN] = LV_ZERO;
        rgb[CH_BLUE]  = LV_ZERO;
        priority if (idx < 5'd8) begin
            rgb[CH_GREEN] = LV_ZERO;
        end
        else if (idx < 5'd12) begin
            rgb[CH_GREEN] = LV_40;
        end
        else if (idx < 5'd19) begin
            rgb[CH_GREEN] = LV_30;
        end
        else if (idx == 5'd19) begin
            rgb[CH_GREEN] = LV_30;
            rgb[CH_BLUE]  = LV_FULL;
        end
        else if (idx == 5'd20) begin
            rgb[CH_RED]   = LV_ZERO;
            rgb[CH_GREEN] = LV_20;
            rgb[CH_BLUE]  = LV_FULL;
        end
        else begin
            rgb[CH_GREEN] = LV_30;
            rgb[CH_BLUE]  = LV_HALF;
        end
        return rgb;
    endfunction

endpackage

`default_nettype wire

[sv/ffle_ram.sv]
`default_nettype none

module ffle_ram #(
    parameter int WIDTH  = 34,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[sv/ffle_mod.sv]
`default_nettype none

module ffle_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ffle_pkg::DRAW_W-1:0]   dividend,
    input  logic [ffle_pkg::LEVEL_W-1:0]  divisor,
    output logic                          done,
    output logic [ffle_pkg::LEVEL_W-1:0]  remainder
);

    import ffle_pkg::*;

    localparam int CNT_W = $clog2(MOD_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DRAW_W-1:0]  num_reg, num_next;
    logic [LEVEL_W-1:0] div_reg, div_next;
    logic [LEVEL_W-1:0] rem_reg, rem_next;
    logic [LEVEL_W:0]   trial;
    logic [LEVEL_W:0]   diff;

    // Restoring reduction, one dividend bit per cycle, most significant first.
    always_comb
    begin
        trial     = {rem_reg, num_reg[DRAW_W-1]};
        diff      = trial - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, div_reg}) ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
            num_next = {num_reg[DRAW_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[sv/ffle_scale.sv]
`default_nettype none

module ffle_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ffle_pkg::LEVEL_W-1:0]  level,
    input  logic [ffle_pkg::COLOR_W-1:0]  color,
    output logic                          done,
    output ffle_pkg::scale_res_t          res
);

    import ffle_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    scl_state_t                        state_reg, state_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [LEVEL_W-1:0]                lvl_reg, lvl_next;
    logic [CHANNELS-1:0][LEVEL_W-1:0]  tbl_reg, tbl_next;
    logic [CHANNELS-1:0][PROD_W-1:0]   acc_reg, acc_next;
    logic [CHANNELS-1:0][QUO_W-1:0]    quo_reg, quo_next;
    logic [CHANNELS-1:0][REM_W-1:0]    r_reg, r_next;
    logic [CHANNELS-1:0][REM_W:0]      trial;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    state_next = SC_MUL;
                end
            end
            SC_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = SC_DIV;
                end
            end
            SC_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = SC_DONE;
                end
            end
            SC_DONE:
            begin
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    // The level is taken in most significant bit first, shift and add into
    // one accumulator per channel; then the top twelve product bits are
    // divided by nine, one bit a cycle.
    always_comb
    begin
        cnt_next = cnt_reg;
        lvl_next = lvl_reg;
        tbl_next = tbl_reg;
        acc_next = acc_reg;
        quo_next = quo_reg;
        r_next   = r_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            trial[c] = {r_reg[c], acc_reg[c][PROD_W-1]};
        end
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    lvl_next = level;
                    tbl_next = color_scale(color);
                    acc_next = '0;
                    quo_next = '0;
                    r_next   = '0;
                end
            end
            SC_MUL:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    acc_next[c] = {acc_reg[c][PROD_W-2:0], 1'b0}
                                + (lvl_reg[LEVEL_W-1] ? PROD_W'(tbl_reg[c]) : PROD_W'(0));
                end
                lvl_next = {lvl_reg[LEVEL_W-2:0], 1'b0};
                cnt_next = (cnt_reg == CNT_W'(MUL_STEPS - 1)) ? '0 : cnt_reg + CNT_W'(1);
            end
            SC_DIV:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    acc_next[c] = {acc_reg[c][PROD_W-2:0], 1'b0};
                    if (trial[c] >= (REM_W + 1)'(DIVISOR))
                    begin
                        r_next[c]   = REM_W'(trial[c] - (REM_W + 1)'(DIVISOR));
                        quo_next[c] = {quo_reg[c][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next[c]   = trial[c][REM_W-1:0];
                        quo_next[c] = {quo_reg[c][QUO_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            SC_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Channel mod 3 is the remainder by nine divided by three.
    always_comb
    begin
        done    = (state_reg == SC_DONE);
        res.quo = quo_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            priority if (r_reg[c] >= R9_TWO)
            begin
                res.rem[c] = 2'd2;
            end
            else if (r_reg[c] >= R9_ONE)
            begin
                res.rem[c] = 2'd1;
            end
            else
            begin
                res.rem[c] = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
        tbl_reg <= tbl_next;
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        r_reg   <= r_next;
    end

endmodule

`default_nettype wire

[sv/ffle_pix_out.sv]
`default_nettype none

module ffle_pix_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  ffle_pkg::scale_res_t        res,
    input  logic [ffle_pkg::PIX_W-1:0]  base,
    output logic                        free,
    output logic                        pixel_valid,
    input  logic                        pixel_stall,
    output ffle_pkg::out_item_t         pixel
);

    import ffle_pkg::*;

    logic                             valid_reg, valid_next;
    logic [1:0]                       sub_reg, sub_next;
    scale_res_t                       res_reg;
    logic [PIX_W-1:0]                 base_reg;
    logic                             take;
    logic                             is_last;
    logic [CHANNELS-1:0][QUO_W:0]     sum;
    logic [CHANNELS-1:0][CHAN_W-1:0]  chan;

    assign take    = valid_reg && !pixel_stall;
    assign is_last = (sub_reg == SUB_LAST);
    assign free    = !valid_reg || (take && is_last);

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
                sub_next   = '0;
            end
            else
            begin
                sub_next = sub_reg + 2'd1;
            end
        end
    end

    // The remainder of each channel is spread over the first sub-pixels.
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum[c]  = (QUO_W + 1)'(res_reg.quo[c])
                    + (QUO_W + 1)'(sub_reg < res_reg.rem[c]);
            chan[c] = (sum[c] > (QUO_W + 1)'(CHAN_MAX)) ? CHAN_MAX : sum[c][CHAN_W-1:0];
        end
        pixel.pixel_index = base_reg + PIX_W'(sub_reg);
        pixel.red_level   = chan[CH_RED];
        pixel.green_level = chan[CH_GREEN];
        pixel.blue_level  = chan[CH_BLUE];
        pixel.last_pixel  = is_last;
    end

    assign pixel_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res;
            base_reg <= base;
        end
    end

endmodule

`default_nettype wire

[sv/flame_flicker_led_engine.sv]
// Flame flicker engine. Each word on the item channel is one update tick for
// one flame; each update that is visible gives three words on the pixel
// channel, the flame's three sub-pixels in order, last_pixel set on the third.
// Both channels move a word at a clock edge where valid is high and stall is
// low. cfg_wr_en writes cfg_wr_data into the flicker threshold at once.
// The engine works on one update at a time. Neither a new flame nor a
// rekindle gives a pixel; an index out of range is dropped in the cycle it is
// taken. A rising or a dying flame puts its pixels out after one memory read,
// a bit-serial multiply and a bit-serial divide by nine; its first pixel is
// offered in the same cycle as the engine can take the next word. A falling
// flame first runs the bit-serial modulo of the flicker draw. The next item
// is taken while the three pixels of the last update still wait.
// Reset clears the flame phases and levels through per-flame valid bits, so
// the block takes items from the first cycle after reset; the threshold
// resets to 3. When the receiver stalls, the pixel word is held and the
// engine waits before handing over the next update's pixels.
`default_nettype none

module flame_flicker_led_engine #(
    parameter int MAX_FLAMES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  ffle_pkg::in_item_t         item,
    output logic                       pixel_valid,
    input  logic                       pixel_stall,
    output ffle_pkg::out_item_t        pixel,
    input  logic                       cfg_wr_en,
    input  logic [ffle_pkg::THR_W-1:0] cfg_wr_data
);

    import ffle_pkg::*;

    localparam int FLAME_SPAN = 1 << FLAME_W;
    localparam int DEPTH      = (MAX_FLAMES < FLAME_SPAN) ? MAX_FLAMES : FLAME_SPAN;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_W    = $bits(flame_entry_t);

    seq_state_t          state_reg, state_next;
    in_item_t            item_reg;
    logic                hit_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [DEPTH-1:0]    valid_reg;

    logic                accept;
    logic                in_range;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    flame_entry_t        wr_entry;
    flame_entry_t        cur;

    logic [LEVEL_W:0]    rise_sum;
    logic                rise_over;
    logic                fall_live;
    logic [LEVEL_W-1:0]  fall_lvl;
    logic [STEP_W-1:0]   new_step;
    logic [LEVEL_W-1:0]  new_peak;
    logic                rekindle;

    logic                mod_start;
    logic                mod_done;
    logic [LEVEL_W-1:0]  mod_rem;
    logic                scl_start;
    logic [LEVEL_W-1:0]  scl_level;
    logic                scl_done;
    scale_res_t          scl_res;
    logic                out_load;
    logic                out_free;
    logic [PIX_W-1:0]    pix_base;

    assign accept   = item_valid && !item_stall;
    assign in_range = int'(item.flame_index) < MAX_FLAMES;
    assign rd_addr  = item.flame_index[ADDR_W-1:0];
    assign wr_addr  = item_reg.flame_index[ADDR_W-1:0];
    assign pix_base = PIX_W'({item_reg.flame_index, 1'b0}) + PIX_W'(item_reg.flame_index);

    // A flame that was never written since reset reads as new with level zero.
    always_comb
    begin
        cur = flame_entry_t'(rd_data);
        if (!hit_reg)
        begin
            cur.phase = PH_NEW;
            cur.level = '0;
        end
    end

    assign rise_sum  = {1'b0, cur.level} + (LEVEL_W + 1)'(cur.step);
    assign rise_over = rise_sum > {1'b0, cur.peak};
    assign fall_live = cur.level > LEVEL_W'(cur.step);
    assign fall_lvl  = cur.level - LEVEL_W'(cur.step);
    assign new_step  = make_step(item_reg.step_draw);
    assign new_peak  = make_peak(item_reg.peak_draw);
    assign rekindle  = mod_rem < thr_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (accept && in_range)
                begin
                    state_next = SQ_READ;
                end
            end
            SQ_READ:
            begin
                unique case (cur.phase)
                    PH_NEW:
                    begin
                        state_next = SQ_IDLE;
                    end
                    PH_RISE:
                    begin
                        state_next = SQ_SCALE;
                    end
                    PH_FALL:
                    begin
                        state_next = fall_live ? SQ_MOD : SQ_SCALE;
                    end
                    default:
                    begin
                        state_next = SQ_IDLE;
                    end
                endcase
            end
            SQ_MOD:
            begin
                if (mod_done)
                begin
                    state_next = rekindle ? SQ_IDLE : SQ_SCALE;
                end
            end
            SQ_SCALE:
            begin
                if (scl_done)
                begin
                    state_next = SQ_HAND;
                end
            end
            SQ_HAND:
            begin
                if (out_free)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // The flame's new state is written back before its pixels are worked out,
    // so a following tick for the same flame always sees it.
    always_comb
    begin
        item_stall = (state_reg != SQ_IDLE);
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_entry   = cur;
        mod_start  = 1'b0;
        scl_start  = 1'b0;
        scl_level  = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                rd_en = accept && in_range;
            end
            SQ_READ:
            begin
                unique case (cur.phase)
                    PH_NEW:
                    begin
                        wr_en          = 1'b1;
                        wr_entry.phase = PH_RISE;
                        wr_entry.level = '0;
                        wr_entry.step  = new_step;
                        wr_entry.peak  = new_peak;
                        wr_entry.color = color_sat(item_reg.color_draw);
                    end
                    PH_RISE:
                    begin
                        wr_en     = 1'b1;
                        scl_start = 1'b1;
                        if (rise_over)
                        begin
                            wr_entry.phase = PH_FALL;
                            wr_entry.level = cur.peak;
                            wr_entry.step  = new_step;
                            scl_level      = cur.peak;
                        end
                        else
                        begin
                            wr_entry.level = rise_sum[LEVEL_W-1:0];
                            scl_level      = rise_sum[LEVEL_W-1:0];
                        end
                    end
                    PH_FALL:
                    begin
                        if (fall_live)
                        begin
                            mod_start = 1'b1;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            wr_entry.phase = PH_NEW;
                            wr_entry.level = '0;
                            scl_start      = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            SQ_MOD:
            begin
                if (mod_done)
                begin
                    wr_en = 1'b1;
                    if (rekindle)
                    begin
                        wr_entry.phase = PH_RISE;
                        wr_entry.step  = new_step;
                        wr_entry.peak  = (new_peak > cur.level) ? new_peak : cur.level;
                    end
                    else
                    begin
                        wr_entry.level = fall_lvl;
                        scl_start      = 1'b1;
                        scl_level      = fall_lvl;
                    end
                end
            end
            SQ_SCALE:
            begin
            end
            SQ_HAND:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            thr_reg   <= THR_RESET;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            hit_reg  <= valid_reg[rd_addr];
        end
    end

    ffle_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENTRY_W'(wr_entry)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffle_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (item_reg.flicker_draw),
        .divisor   (fall_lvl),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    ffle_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scl_start),
        .level (scl_level),
        .color (cur.color),
        .done  (scl_done),
        .res   (scl_res)
    );

    ffle_pix_out u_pix_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .res         (scl_res),
        .base        (pix_base),
        .free        (out_free),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

endmodule

`default_nettype wire

[sv/ffle_checker.sv]
`default_nettype none

module ffle_checker #(
    parameter int MAX_FLAMES = 64
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_stall,
    input ffle_pkg::in_item_t         item,
    input logic                       pixel_valid,
    input logic                       pixel_stall,
    input ffle_pkg::out_item_t        pixel
);

    logic pixel_take;
    logic item_take;

    assign pixel_take = pixel_valid && !pixel_stall;
    assign item_take  = item_valid && !item_stall && (int'(item.flame_index) < MAX_FLAMES);

    // A stalled pixel word stays offered unchanged.
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("pixel word changed while stalled");

    // The three sub-pixels of one update follow without a gap.
    a_pixel_burst: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_take && !pixel.last_pixel |=> pixel_valid)
        else $error("gap inside the pixels of one update");

    a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_take && !pixel.last_pixel |=> pixel.pixel_index == $past(pixel.pixel_index) + 8'd1)
        else $error("sub-pixel index out of order");

    // A flame in range occupies the engine for at least the next cycle.
    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> item_stall)
        else $error("engine took a second item straight after one in range");

endmodule

bind flame_flicker_led_engine ffle_checker #(.MAX_FLAMES(MAX_FLAMES)) u_ffle_checker (.*);

`default_nettype wire
